[hdl/msc_pkg.sv]
// Shared types and constants for the marching-squares contour block.
// Used by the channel interfaces, msc_front, msc_back and the top level.
package msc_pkg;

  localparam int PIX_W       = 8;
  localparam int COORD_W     = 18;
  localparam int CASE_W      = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int WIDTH_CFG_W = 11;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ISO_LEVEL   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b1;

  localparam logic [PIX_W-1:0]       ISO_RESET   = 8'd128;
  localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET = 11'd1024;

  // cell cases with special handling
  localparam logic [CASE_W-1:0] CASE_EMPTY  = 4'b0000;
  localparam logic [CASE_W-1:0] CASE_FULL   = 4'b1111;
  localparam logic [CASE_W-1:0] CASE_SADDLE_A = 4'b0110;
  localparam logic [CASE_W-1:0] CASE_SADDLE_B = 4'b1001;

  // corners of one cell and its resolved case
  typedef struct packed {
    logic [PIX_W-1:0]  ul;
    logic [PIX_W-1:0]  ur;
    logic [PIX_W-1:0]  ll;
    logic [PIX_W-1:0]  lr;
    logic [CASE_W-1:0] cs;
  } cell_t;

endpackage

[hdl/msc_pixel_if.sv]
// Pixel input channel and segment output channel, plus configuration write channel.
// Depends on msc_pkg.
interface msc_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [msc_pkg::PIX_W-1:0] pixel_value;
  logic                      start_of_frame;
  modport source (output valid, pixel_value, start_of_frame, input ready);
  modport sink (input valid, pixel_value, start_of_frame, output ready);
endinterface

interface msc_seg_if;
  logic                        valid;
  logic                        ready;
  logic [msc_pkg::COORD_W-1:0] start_x;
  logic [msc_pkg::COORD_W-1:0] start_y;
  logic [msc_pkg::COORD_W-1:0] end_x;
  logic [msc_pkg::COORD_W-1:0] end_y;
  logic [msc_pkg::CASE_W-1:0]  cell_case;
  logic                        last_segment;
  modport source (output valid, start_x, start_y, end_x, end_y, cell_case, last_segment,
                  input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, cell_case, last_segment,
                output ready);
endinterface

interface msc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [msc_pkg::CFG_IDX_W-1:0]  index;
  logic [msc_pkg::CFG_DATA_W-1:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

[hdl/msc_front.sv]
// Front end: raster counters, line store and cell classification.
// Depends on msc_pkg and msc_pixel_if.
module msc_front #(
  parameter int MAX_WIDTH  = msc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = msc_pkg::MAX_HEIGHT_DEF,
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  msc_pixel_if.sink                          pix_in,
  input  logic [msc_pkg::PIX_W-1:0]          iso_level,
  input  logic [msc_pkg::WIDTH_CFG_W-1:0]    image_width,
  output logic                               q_valid,
  input  logic                               q_ready,
  output msc_pkg::cell_t                     q_cell,
  output logic [COL_W-1:0]                   q_col,
  output logic [ROW_W-1:0]                   q_row
);

  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);

  logic [msc_pkg::PIX_W-1:0] row_store [MAX_WIDTH];

  logic                      busy;
  logic [COL_W-1:0]          column_count;
  logic [ROW_W-1:0]          row_count;
  logic [COL_W-1:0]          col;
  logic [ROW_W-1:0]          row;
  logic [msc_pkg::PIX_W-1:0] pix;
  logic [msc_pkg::PIX_W-1:0] above;
  logic [msc_pkg::PIX_W-1:0] left_upper_pixel;
  logic [msc_pkg::PIX_W-1:0] left_lower_pixel;

  logic [WCNT_W-1:0]         w_eff;
  logic [COL_W-1:0]          col_cur;
  logic [ROW_W-1:0]          row_cur;
  logic [WCNT_W-1:0]         col_inc;
  logic [COL_W-1:0]          column_count_next;
  logic [ROW_W-1:0]          row_count_next;
  logic                      accept;
  logic [msc_pkg::CASE_W-1:0] cs_raw;
  logic [msc_pkg::CASE_W-1:0] cs;
  logic [msc_pkg::PIX_W+1:0] corner_sum;
  logic                      emit;
  logic                      done;

  // clamp the configured width into the supported range
  always_comb begin
    if (image_width < 11'd2) begin
      w_eff = WCNT_W'(2);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WCNT_W'(MAX_WIDTH);
    end else begin
      w_eff = WCNT_W'(image_width);
    end
  end

  function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
    if (32'(r) < MAX_HEIGHT - 1) begin
      return r + ROW_W'(1);
    end
    return r;
  endfunction

  // position of the incoming pixel and the counters after it
  always_comb begin
    if (pix_in.start_of_frame) begin
      col_cur = '0;
      row_cur = '0;
    end else if (WCNT_W'(column_count) >= w_eff) begin
      col_cur = '0;
      row_cur = row_inc(row_count);
    end else begin
      col_cur = column_count;
      row_cur = row_count;
    end
    col_inc = WCNT_W'(col_cur) + WCNT_W'(1);
    if (col_inc >= w_eff) begin
      column_count_next = '0;
      row_count_next    = row_inc(row_cur);
    end else begin
      column_count_next = col_inc[COL_W-1:0];
      row_count_next    = row_cur;
    end
  end

  assign pix_in.ready = !busy;
  assign accept       = pix_in.valid && !busy;

  // classify the closed cell and resolve saddles
  always_comb begin
    cs_raw = {left_upper_pixel >= iso_level, above >= iso_level,
              left_lower_pixel >= iso_level, pix >= iso_level};
    corner_sum = 10'(left_upper_pixel) + 10'(above) + 10'(left_lower_pixel) + 10'(pix);
    cs = cs_raw;
    if (corner_sum < {iso_level, 2'b00}) begin
      if (cs_raw == msc_pkg::CASE_SADDLE_A) begin
        cs = msc_pkg::CASE_SADDLE_B;
      end else if (cs_raw == msc_pkg::CASE_SADDLE_B) begin
        cs = msc_pkg::CASE_SADDLE_A;
      end
    end
    emit = (row != '0) && (col != '0) && (cs != msc_pkg::CASE_EMPTY) &&
           (cs != msc_pkg::CASE_FULL);
    done = busy && (!emit || q_ready);
  end

  assign q_valid = busy && emit;
  assign q_cell  = '{ul: left_upper_pixel, ur: above, ll: left_lower_pixel, lr: pix, cs: cs};
  assign q_col   = col;
  assign q_row   = row;

  // line store: read at acceptance, write back once the cell is handed on
  always_ff @(posedge clk) begin
    if (accept) begin
      above <= row_store[col_cur];
      pix   <= pix_in.pixel_value;
      col   <= col_cur;
      row   <= row_cur;
    end
    if (done) begin
      row_store[col] <= pix;
    end
  end

  // control state and the left-hand corners
  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      column_count     <= '0;
      row_count        <= '0;
      left_upper_pixel <= '0;
      left_lower_pixel <= '0;
    end else begin
      if (accept) begin
        busy         <= 1'b1;
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end else if (done) begin
        busy             <= 1'b0;
        left_upper_pixel <= above;
        left_lower_pixel <= pix;
      end
    end
  end

endmodule

[hdl/msc_queue.sv]
// Two-entry queue between the front end and the segment generator.
// Depends on nothing but its width parameter.
module msc_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic [DATA_W-1:0] slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // store incoming transaction
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

[hdl/msc_back.sv]
// Back end: edge interpolation by four shared-step dividers and segment output.
// Depends on msc_pkg and msc_seg_if.
module msc_back #(
  parameter int MAX_WIDTH  = msc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = msc_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = msc_pkg::FRAC_BITS_DEF,
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  msc_pkg::cell_t            q_cell,
  input  logic [COL_W-1:0]          q_col,
  input  logic [ROW_W-1:0]          q_row,
  input  logic [msc_pkg::PIX_W-1:0] iso_level,
  msc_seg_if.source                 seg_out
);

  localparam int DIVD_W  = msc_pkg::PIX_W + FRAC_BITS + 1;
  localparam int QUO_W   = FRAC_BITS + 1;
  localparam int STEPS   = FRAC_BITS + 1;
  localparam int STEP_W  = $clog2(STEPS + 1);
  localparam int PER_CYC = 3;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SEG0 = 2'd2;
  localparam logic [1:0] S_SEG1 = 2'd3;

  // edge points
  localparam logic [1:0] P_L = 2'd0;
  localparam logic [1:0] P_R = 2'd1;
  localparam logic [1:0] P_T = 2'd2;
  localparam logic [1:0] P_B = 2'd3;

  logic [1:0]               state;
  logic [1:0]               state_next;
  logic [STEP_W-1:0]        steps;
  logic [msc_pkg::CASE_W-1:0] cs;
  logic [COL_W-1:0]         col;
  logic [ROW_W-1:0]         row;
  logic [DIVD_W-1:0]        rem [4];
  logic [DIVD_W-1:0]        dsh [4];
  logic [QUO_W-1:0]         quot [4];
  logic [DIVD_W-1:0]        rem_next [4];
  logic [DIVD_W-1:0]        dsh_next [4];
  logic [QUO_W-1:0]         quot_next [4];
  logic [msc_pkg::PIX_W-1:0] ea [4];
  logic [msc_pkg::PIX_W-1:0] eb [4];
  logic [msc_pkg::PIX_W-1:0] num [4];
  logic [msc_pkg::PIX_W-1:0] den [4];

  logic                     out_valid;
  logic                     out_free;
  logic [31:0]              lc;
  logic [31:0]              rc;
  logic [31:0]              uy;
  logic [31:0]              ly;
  logic [msc_pkg::COORD_W-1:0] px [4];
  logic [msc_pkg::COORD_W-1:0] py [4];
  logic [1:0]               s0a;
  logic [1:0]               s0b;
  logic [1:0]               s1a;
  logic [1:0]               s1b;
  logic                     two;
  logic [1:0]               pa;
  logic [1:0]               pb;

  // edge corner pairs, first corner is left or upper
  always_comb begin
    ea[P_L] = q_cell.ul; eb[P_L] = q_cell.ll;
    ea[P_R] = q_cell.ur; eb[P_R] = q_cell.lr;
    ea[P_T] = q_cell.ul; eb[P_T] = q_cell.ur;
    ea[P_B] = q_cell.ll; eb[P_B] = q_cell.lr;
    for (int i = 0; i < 4; i++) begin
      num[i] = (iso_level >= ea[i]) ? iso_level - ea[i] : ea[i] - iso_level;
      den[i] = (eb[i] >= ea[i]) ? eb[i] - ea[i] : ea[i] - eb[i];
    end
  end

  // up to three restoring steps per cycle on each divider
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rem_next[i]  = rem[i];
      dsh_next[i]  = dsh[i];
      quot_next[i] = quot[i];
      for (int j = 0; j < PER_CYC; j++) begin
        if (32'(steps) > j) begin
          if (rem_next[i] >= dsh_next[i]) begin
            rem_next[i]  = rem_next[i] - dsh_next[i];
            quot_next[i] = {quot_next[i][QUO_W-2:0], 1'b1};
          end else begin
            quot_next[i] = {quot_next[i][QUO_W-2:0], 1'b0};
          end
          dsh_next[i] = dsh_next[i] >> 1;
        end
      end
    end
  end

  assign q_ready  = (state == S_IDLE);
  assign out_free = !out_valid || seg_out.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_valid) state_next = S_DIV;
      S_DIV:  if (32'(steps) <= PER_CYC) state_next = S_SEG0;
      S_SEG0: if (out_free) state_next = two ? S_SEG1 : S_IDLE;
      S_SEG1: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // hold cell data and iterate the dividers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      cs  <= q_cell.cs;
      col <= q_col;
      row <= q_row;
      for (int i = 0; i < 4; i++) begin
        rem[i]  <= (DIVD_W'(num[i]) << FRAC_BITS) + DIVD_W'(den[i] >> 1);
        dsh[i]  <= DIVD_W'(den[i]) << FRAC_BITS;
        quot[i] <= '0;
      end
    end else if (state == S_DIV) begin
      for (int i = 0; i < 4; i++) begin
        rem[i]  <= rem_next[i];
        dsh[i]  <= dsh_next[i];
        quot[i] <= quot_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      steps <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && q_valid) begin
        steps <= STEP_W'(STEPS);
      end else if (state == S_DIV) begin
        steps <= (32'(steps) > PER_CYC) ? steps - STEP_W'(PER_CYC) : '0;
      end
    end
  end

  // edge point coordinates
  always_comb begin
    lc = (32'(col) - 32'd1) << FRAC_BITS;
    rc = 32'(col) << FRAC_BITS;
    uy = (32'(row) - 32'd1) << FRAC_BITS;
    ly = 32'(row) << FRAC_BITS;
    px[P_L] = msc_pkg::COORD_W'(lc);
    py[P_L] = msc_pkg::COORD_W'(uy + 32'(quot[P_L]));
    px[P_R] = msc_pkg::COORD_W'(rc);
    py[P_R] = msc_pkg::COORD_W'(uy + 32'(quot[P_R]));
    px[P_T] = msc_pkg::COORD_W'(lc + 32'(quot[P_T]));
    py[P_T] = msc_pkg::COORD_W'(uy);
    px[P_B] = msc_pkg::COORD_W'(lc + 32'(quot[P_B]));
    py[P_B] = msc_pkg::COORD_W'(ly);
  end

  // segment endpoints by case
  always_comb begin
    s0a = P_T; s0b = P_L; s1a = P_R; s1b = P_B; two = 1'b0;
    case (cs)
      4'hE, 4'h1: begin s0a = P_B; s0b = P_R; end
      4'hD, 4'h2: begin s0a = P_B; s0b = P_L; end
      4'hB, 4'h4: begin s0a = P_T; s0b = P_R; end
      4'h7, 4'h8: begin s0a = P_T; s0b = P_L; end
      4'hC, 4'h3: begin s0a = P_R; s0b = P_L; end
      4'hA, 4'h5: begin s0a = P_T; s0b = P_B; end
      msc_pkg::CASE_SADDLE_A: begin
        s0a = P_L; s0b = P_T; s1a = P_R; s1b = P_B; two = 1'b1;
      end
      msc_pkg::CASE_SADDLE_B: begin
        s0a = P_R; s0b = P_T; s1a = P_L; s1b = P_B; two = 1'b1;
      end
      default: begin s0a = P_T; s0b = P_L; end
    endcase
    pa = (state == S_SEG1) ? s1a : s0a;
    pb = (state == S_SEG1) ? s1b : s0b;
  end

  // output register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if ((state == S_SEG0 || state == S_SEG1) && out_free) begin
      seg_out.start_x      <= px[pa];
      seg_out.start_y      <= py[pa];
      seg_out.end_x        <= px[pb];
      seg_out.end_y        <= py[pb];
      seg_out.cell_case    <= cs;
      seg_out.last_segment <= (state == S_SEG1) || !two;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_SEG0 || state == S_SEG1) && out_free) begin
      out_valid <= 1'b1;
    end else if (seg_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign seg_out.valid = out_valid;

endmodule

[hdl/marching_squares_contour.sv]
// Marching-squares contour extractor, top level with configuration registers.
// Depends on msc_pkg, the channel interfaces, msc_front, msc_queue and msc_back.
//
// Pixels enter on pix_in in raster order; start_of_frame marks column 0 of row 0.
// Each pixel at column >= 1 of row >= 1 closes a 2x2 cell; the cell gives zero,
// one or two segments on seg_out, last_segment set on the final one of a cell.
// Configuration goes through cfg: index 0 is iso_level, index 1 is image_width.
// cfg is always ready; write it only while the block is idle.
// The front end takes a new pixel only after the last one is written back (line
// store read, then write-back) and its cell is handed on. A cell that yields
// segments occupies the back end for the edge division, then for each segment in
// turn; a two-entry queue absorbs the difference.
// With nothing waiting, a closing pixel passes the front-end register, the queue,
// the divider sequence and the output register before seg_out.valid rises.
// Reset (rst, synchronous) clears counters, left corners, queue and sequencer, and
// sets iso_level to 128 and image_width to 1024; the line store is not cleared.
// When seg_out stalls, the output register holds its segment, the back end waits,
// the queue fills and pix_in.ready then drops; nothing is lost.
module marching_squares_contour #(
  parameter int MAX_WIDTH  = msc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = msc_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = msc_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  msc_pixel_if.sink pix_in,
  msc_seg_if.source seg_out,
  msc_cfg_if.sink   cfg
);

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CELL_W = $bits(msc_pkg::cell_t);
  localparam int QD_W   = CELL_W + COL_W + ROW_W;

  logic [msc_pkg::PIX_W-1:0]       iso_level;
  logic [msc_pkg::WIDTH_CFG_W-1:0] image_width;

  logic              f_valid;
  logic              f_ready;
  msc_pkg::cell_t    f_cell;
  logic [COL_W-1:0]  f_col;
  logic [ROW_W-1:0]  f_row;
  logic              b_valid;
  logic              b_ready;
  logic [QD_W-1:0]   b_data;
  msc_pkg::cell_t    b_cell;
  logic [COL_W-1:0]  b_col;
  logic [ROW_W-1:0]  b_row;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iso_level   <= msc_pkg::ISO_RESET;
      image_width <= msc_pkg::WIDTH_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == msc_pkg::REG_ISO_LEVEL) begin
        iso_level <= cfg.wdata[msc_pkg::PIX_W-1:0];
      end else if (cfg.index == msc_pkg::REG_IMAGE_WIDTH) begin
        image_width <= cfg.wdata;
      end
    end
  end

  msc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .pix_in      (pix_in),
    .iso_level   (iso_level),
    .image_width (image_width),
    .q_valid     (f_valid),
    .q_ready     (f_ready),
    .q_cell      (f_cell),
    .q_col       (f_col),
    .q_row       (f_row)
  );

  msc_queue #(
    .DATA_W (QD_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_cell, f_col, f_row}),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  assign b_cell = b_data[QD_W-1 -: CELL_W];
  assign b_col  = b_data[ROW_W +: COL_W];
  assign b_row  = b_data[ROW_W-1:0];

  msc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_cell    (b_cell),
    .q_col     (b_col),
    .q_row     (b_row),
    .iso_level (iso_level),
    .seg_out   (seg_out)
  );

endmodule
